// ----- rtl/core/ile_pkg.sv -----
// Shared constants, codes and types for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

   localparam int Capacity   = 64;
   localparam int IdxWidth   = $clog2(Capacity);
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int DataWidth  = 32;
   localparam int PosWidth   = 16;
   localparam int ActWidth   = 3;
   localparam int StatWidth  = 2;

   // Stream payload layout
   localparam int ReqBits  = ActWidth + PosWidth + DataWidth;
   localparam int ReqBytes = (ReqBits + 7) / 8;
   localparam int RspBits  = DataWidth + StatWidth + CountWidth;
   localparam int RspBytes = (RspBits + 7) / 8;

   localparam logic [DataWidth-1:0] MinusOne = '1;

   typedef enum logic [ActWidth-1:0] {
      ACT_GET        = 3'd0,
      ACT_INS_HEAD   = 3'd1,
      ACT_INS_TAIL   = 3'd2,
      ACT_INS_AT     = 3'd3,
      ACT_DELETE     = 3'd4
   } action_type;

   typedef enum logic [StatWidth-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type           op;
      logic [IdxWidth-1:0]   pos;
      logic [DataWidth-1:0]  data;
   } cell_cmd_type;

endpackage

// ----- rtl/core/ile_cell.sv -----
// One list slot: holds an entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps

module ile_cell (
   input  logic                           clock,
   input  logic [ile_pkg::IdxWidth-1:0]   cell_index,
   input  ile_pkg::cell_cmd_type          cmd,
   input  logic [ile_pkg::DataWidth-1:0]  left_data,
   input  logic [ile_pkg::DataWidth-1:0]  right_data,
   output logic [ile_pkg::DataWidth-1:0]  entry_data,
   output logic [ile_pkg::DataWidth-1:0]  read_data
);

   logic [ile_pkg::DataWidth-1:0] entry_ff;
   logic [ile_pkg::DataWidth-1:0] entry_in;
   logic                          hit;
   logic                          above;

   assign hit   = (cell_index == cmd.pos);
   assign above = (cell_index > cmd.pos);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         ile_pkg::CELL_INSERT: begin
            if (hit) begin
               entry_in = cmd.data;
            end else if (above) begin
               entry_in = left_data;
            end
         end
         ile_pkg::CELL_DELETE: begin
            // slots at or past the removed one pull from the right
            if (hit || above) begin
               entry_in = right_data;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_data = entry_ff;
   assign read_data  = hit ? entry_ff : '0;

endmodule

// ----- rtl/core/indexed_list_engine_core.sv -----
// Top level of the indexed list engine: command decode, cell row and result register.
`timescale 1ns / 1ps

// Position-addressed list of up to 64 signed 32-bit entries held in a row of
// cells, one entry per cell. Each request item carries get, insert at head,
// insert at tail, insert before a position, or delete at a position; every
// item returns exactly one response item with the value read (-1 unless a
// get succeeded), a status and the entry count after the item. An insert or
// delete moves every later entry one cell in the same clock, so the block
// takes one item per cycle while the response register drains; a get
// selects the addressed cell through an OR tree across the row. Entries
// are not cleared at reset: only positions below the count are ever read.

module indexed_list_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: action[2:0], position[18:3], value[50:19], zero pad to 56
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ile_pkg::ReqBytes*8-1:0]      req_tdata,
   // rsp_tdata: read_value[31:0], status[33:32], entry_count[40:34], zero pad to 48
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ile_pkg::RspBytes*8-1:0]      rsp_tdata
);

   logic [ile_pkg::ActWidth-1:0]    req_action;
   logic [ile_pkg::PosWidth-1:0]    req_position;
   logic [ile_pkg::DataWidth-1:0]   req_value;
   logic                            accept;

   logic [ile_pkg::CountWidth-1:0]  count_ff;
   logic [ile_pkg::CountWidth-1:0]  count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [ile_pkg::DataWidth-1:0]   rsp_read_ff;
   logic [ile_pkg::DataWidth-1:0]   rsp_read_in;
   ile_pkg::status_type             rsp_status_ff;
   ile_pkg::status_type             rsp_status_in;

   logic                            pos_neg;
   logic [ile_pkg::PosWidth-1:0]    pos_clamp;
   logic [ile_pkg::PosWidth-1:0]    count_ext;
   logic                            full;
   logic                            get_ok;
   ile_pkg::status_type             status;
   ile_pkg::cell_cmd_type           cmd;
   logic [ile_pkg::DataWidth-1:0]   read_sel;

   logic [ile_pkg::DataWidth-1:0]   cell_data [ile_pkg::Capacity];
   logic [ile_pkg::DataWidth-1:0]   cell_read [ile_pkg::Capacity];

   assign req_action   = req_tdata[ile_pkg::ActWidth-1:0];
   assign req_position = req_tdata[ile_pkg::ActWidth +: ile_pkg::PosWidth];
   assign req_value    = req_tdata[ile_pkg::ActWidth + ile_pkg::PosWidth +: ile_pkg::DataWidth];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign pos_neg   = req_position[ile_pkg::PosWidth-1];
   assign pos_clamp = pos_neg ? '0 : req_position;
   assign count_ext = ile_pkg::PosWidth'(count_ff);
   assign full      = (count_ff >= ile_pkg::CountWidth'(ile_pkg::Capacity));

   // Command decode
   always_comb begin
      status   = ile_pkg::ST_DONE;
      get_ok   = 1'b0;
      cmd.op   = ile_pkg::CELL_HOLD;
      cmd.pos  = pos_clamp[ile_pkg::IdxWidth-1:0];
      cmd.data = req_value;
      unique case (req_action) inside
         ile_pkg::ACT_GET: begin
            if (pos_neg || pos_clamp >= count_ext) begin
               status = ile_pkg::ST_RANGE;
            end else begin
               get_ok = 1'b1;
            end
         end
         ile_pkg::ACT_INS_HEAD, ile_pkg::ACT_INS_TAIL: begin
            if (full) begin
               status = ile_pkg::ST_FULL;
            end else begin
               cmd.op  = ile_pkg::CELL_INSERT;
               cmd.pos = (req_action == ile_pkg::ACT_INS_HEAD) ? '0
                         : count_ff[ile_pkg::IdxWidth-1:0];
            end
         end
         ile_pkg::ACT_INS_AT: begin
            // range test takes precedence over full
            if (pos_clamp > count_ext) begin
               status = ile_pkg::ST_RANGE;
            end else if (full) begin
               status = ile_pkg::ST_FULL;
            end else begin
               cmd.op = ile_pkg::CELL_INSERT;
            end
         end
         ile_pkg::ACT_DELETE: begin
            if (pos_neg || pos_clamp >= count_ext) begin
               status = ile_pkg::ST_RANGE;
            end else begin
               cmd.op = ile_pkg::CELL_DELETE;
            end
         end
         default: status = ile_pkg::ST_RANGE;
      endcase
      if (!accept) begin
         cmd.op = ile_pkg::CELL_HOLD;
      end
   end

   // Row of cells; neighbor links at the ends are tied off
   for (genvar i = 0; i < ile_pkg::Capacity; i++) begin : g_cell
      logic [ile_pkg::DataWidth-1:0] left_data;
      logic [ile_pkg::DataWidth-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == ile_pkg::Capacity - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ile_cell u_cell (
         .clock      (clock),
         .cell_index (ile_pkg::IdxWidth'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .entry_data (cell_data[i]),
         .read_data  (cell_read[i])
      );
   end

   always_comb begin
      read_sel = '0;
      for (int i = 0; i < ile_pkg::Capacity; i++) begin
         read_sel = read_sel | cell_read[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_read_in   = get_ok ? read_sel : ile_pkg::MinusOne;
         rsp_status_in = status;
         case (cmd.op)
            ile_pkg::CELL_INSERT: count_in = count_ff + 1'b1;
            ile_pkg::CELL_DELETE: count_in = count_ff - 1'b1;
            default:              count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_ff   <= rsp_read_in;
      rsp_status_ff <= rsp_status_in;
   end

   // count_ff after an item equals the reported entry count
   logic [ile_pkg::CountWidth-1:0] rsp_count_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ile_pkg::RspBytes*8 - ile_pkg::RspBits){1'b0}},
                        rsp_count_ff, rsp_status_ff, rsp_read_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ile_pkg::CountWidth'(ile_pkg::Capacity))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.op == ile_pkg::CELL_INSERT |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && status == ile_pkg::ST_FULL |->
      count_ff == ile_pkg::CountWidth'(ile_pkg::Capacity))
      else $error("full status with room left");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(rsp_tready && req_tvalid) |-> rsp_count_ff == count_ff)
      else $error("reported count differs from list count");
`endif

endmodule
